FILE: rtl/core/grvw_pkg.sv
// Shared types, constants and the tangent magnitude table for the vertical-wall ray caster.
// Used by grvw_front, grvw_queue, grvw_back and grid_ray_vertical_wall_cast_core.
// No dependencies.
package grvw_pkg;

	// Field widths.
	localparam int POS_W   = 18;
	localparam int ANG_W   = 10;
	localparam int OUT_W   = 20;
	localparam int STEP_W  = 4;
	localparam int TAN_W   = 17;
	localparam int RX_W    = 21;
	localparam int RY_W    = 26;
	localparam int YO_W    = 23;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// Grid and ray constants, all positions in Q8 pixels.
	localparam logic signed [RX_W-1:0] TILE_Q8   = 21'sd16384;
	localparam logic [STEP_W-1:0]      MAX_STEPS = 4'd8;
	localparam logic [ANG_W-1:0]       ANG_QTR   = 10'd256;
	localparam logic [ANG_W-1:0]       ANG_3QTR  = 10'd768;
	localparam logic [8:0]             ANG_HALF_SPAN = 9'd256;
	localparam logic [9:0]             ANG_HALF  = 10'd512;
	localparam logic [15:0]            TAN_SAT_POS = 16'd32767;

	// Output saturation bounds.
	localparam logic signed [RY_W-1:0] OUT_MAX = 26'sd524287;
	localparam logic signed [RY_W-1:0] OUT_MIN = -26'sd524288;

	// Series arithmetic constants for the table build.
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// One prepared ray, handed from the front to the back.
	typedef struct packed {
		logic                   deg;
		logic                   left;
		logic signed [RX_W-1:0] rx;
		logic signed [RY_W-1:0] ry;
		logic signed [YO_W-1:0] yo;
	} ray_job_t;

	typedef logic [15:0] tan_rom_t [256];

	// Restoring long division used only while the table is built.
	function automatic logic [63:0] const_udiv(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Magnitude of tan(2*pi*i/1024) in Q8.8, rounded, clipped at 32768.
	function automatic tan_rom_t build_tan_rom();
		tan_rom_t    rom;
		logic [63:0] phi;
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ct;
		logic [63:0] mag;
		logic [63:0] dv_s;
		logic [63:0] dv_c;
		longint      s;
		longint      c;
		for (int idx = 0; idx < 256; idx++) begin
			phi = (PI_Q30 * 64'(2 * idx)) >> 10;
			x2  = (phi * phi) >> 30;
			s   = longint'(phi);
			st  = phi;
			c   = longint'(ONE_Q30);
			ct  = ONE_Q30;
			for (int i = 1; i <= 12; i++) begin
				dv_s = 64'((2 * i) * (2 * i + 1));
				dv_c = 64'((2 * i - 1) * (2 * i));
				st = const_udiv((st * x2) >> 30, dv_s);
				ct = const_udiv((ct * x2) >> 30, dv_c);
				if ((i & 1) == 1) begin
					s = s - longint'(st);
					c = c - longint'(ct);
				end else begin
					s = s + longint'(st);
					c = c + longint'(ct);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			if (c <= 0) begin
				mag = 64'd32768;
			end else begin
				mag = const_udiv(64'(s) * 64'd256 + (64'(c) >> 1), 64'(c));
			end
			if (mag > 64'd32768) begin
				mag = 64'd32768;
			end
			rom[idx] = mag[15:0];
		end
		return rom;
	endfunction

	localparam tan_rom_t TAN_ROM = build_tan_rom();

	// Clamp a wide signed coordinate to the signed Q11.8 output range.
	function automatic logic [OUT_W-1:0] sat_out(logic signed [RY_W-1:0] v);
		logic signed [RY_W-1:0] r;
		r = v;
		if (v > OUT_MAX) begin
			r = OUT_MAX;
		end
		if (v < OUT_MIN) begin
			r = OUT_MIN;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

FILE: rtl/core/grvw_front.sv
// Front part: accepts ray beats, classifies the angle, looks up the slope and
// computes the first grid-line crossing. Depends on grvw_pkg.
module grvw_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// player_x [17:0], player_y [35:18], ray_angle [45:36], zero pad [47:46]
	input  logic [grvw_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           push,
	output grvw_pkg::ray_job_t             push_job,
	input  logic                           q_full
);
	import grvw_pkg::*;

	logic [POS_W-1:0] in_px;
	logic [POS_W-1:0] in_py;
	logic [ANG_W-1:0] in_ang;
	logic             in_neg;
	logic [9:0]       idx_w;
	logic [15:0]      mag;
	logic signed [TAN_W-1:0] tan_w;
	logic             in_deg;
	logic             in_left;
	logic             accept;

	logic                    v_s1;
	logic [POS_W-1:0]        px_s1;
	logic [POS_W-1:0]        py_s1;
	logic signed [TAN_W-1:0] tan_s1;
	logic                    deg_s1;
	logic                    left_s1;

	logic signed [RX_W-1:0] bx;
	logic signed [RX_W-1:0] rx0;
	logic signed [RX_W-1:0] dx_full;
	logic signed [15:0]     dx;
	logic signed [32:0]     prod;
	logic signed [24:0]     dy;
	logic signed [RY_W-1:0] ry0;
	logic signed [YO_W-1:0] t64;

	assign in_px  = s_tdata[17:0];
	assign in_py  = s_tdata[35:18];
	assign in_ang = s_tdata[45:36];

	// Fold the angle onto the half-turn tangent period and its mirror.
	assign in_neg  = (in_ang[8:0] > ANG_HALF_SPAN);
	assign idx_w   = in_neg ? (ANG_HALF - {1'b0, in_ang[8:0]}) : {1'b0, in_ang[8:0]};
	assign mag     = TAN_ROM[idx_w[7:0]];
	always_comb begin
		if (in_neg) begin
			tan_w = -$signed({1'b0, mag});
		end else if (mag > TAN_SAT_POS) begin
			tan_w = $signed({1'b0, TAN_SAT_POS});
		end else begin
			tan_w = $signed({1'b0, mag});
		end
	end
	assign in_deg  = (in_ang == ANG_QTR) || (in_ang == ANG_3QTR);
	assign in_left = (in_ang > ANG_QTR) && (in_ang < ANG_3QTR);

	assign s_tready = !v_s1 || !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = v_s1 && !q_full;

	// Stage 1 holds the classified beat until the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= in_px;
			py_s1   <= in_py;
			tan_s1  <= tan_w;
			deg_s1  <= in_deg;
			left_s1 <= in_left;
		end
	end

	// First vertical line crossing and per-step y offset.
	assign bx      = $signed({3'b000, px_s1[17:14], 14'b0});
	assign rx0     = left_s1 ? (bx - 21'sd1) : (bx + TILE_Q8);
	assign dx_full = rx0 - $signed({3'b000, px_s1});
	assign dx      = dx_full[15:0];
	assign prod    = dx * tan_s1;
	assign dy      = prod[32:8];
	assign ry0     = $signed({8'b0, py_s1}) + $signed({dy[24], dy});
	assign t64     = {tan_s1, 6'b0};

	always_comb begin
		push_job.deg  = deg_s1;
		push_job.left = left_s1;
		push_job.yo   = left_s1 ? -t64 : t64;
		if (deg_s1) begin
			push_job.rx = $signed({3'b000, px_s1});
			push_job.ry = $signed({8'b0, py_s1});
		end else begin
			push_job.rx = rx0;
			push_job.ry = ry0;
		end
	end

endmodule

FILE: rtl/core/grvw_queue.sv
// Two-entry queue of prepared rays between the front and the back.
// Depends on grvw_pkg.
module grvw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  grvw_pkg::ray_job_t push_job,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output grvw_pkg::ray_job_t head
);
	import grvw_pkg::*;

	ray_job_t   mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: rtl/core/grvw_back.sv
// Back part: steps a prepared ray across vertical grid lines one per cycle,
// tests the wall bitmap and holds the result beat. Depends on grvw_pkg.
module grvw_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [63:0]                     cfg_wr_data,
	input  logic                            q_valid,
	input  grvw_pkg::ray_job_t              q_head,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit_x [19:0], hit_y [39:20], steps_taken [43:40], zero pad [47:44]
	output logic [grvw_pkg::OUT_TDATA_W-1:0] m_tdata,
	// wall_found [0]
	output logic                            m_tuser
);
	import grvw_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                   st_q;
	logic                   deg_q;
	logic                   left_q;
	logic signed [RX_W-1:0] rx_q;
	logic signed [RY_W-1:0] ry_q;
	logic signed [YO_W-1:0] yo_q;
	logic [STEP_W-1:0]      steps_q;
	logic [63:0]            wall_map_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_user_q;

	logic       in_map;
	logic [5:0] tile_idx;
	logic       wall;
	logic       at_max;
	logic       done;
	logic       out_free;

	// Cell under the ray point; points outside the map count as empty.
	assign in_map   = (rx_q[20:17] == 4'd0) && (ry_q[25:17] == 9'd0);
	assign tile_idx = {ry_q[16:14], rx_q[16:14]};
	assign wall     = in_map && wall_map_q[tile_idx];
	assign at_max   = (steps_q == MAX_STEPS);
	assign done     = deg_q || at_max || wall;

	assign out_free = !out_valid_q || m_tready;
	assign q_pop    = (st_q == ST_IDLE) && q_valid;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Wall bitmap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q <= 64'd0;
		end else if (cfg_wr_en) begin
			wall_map_q <= cfg_wr_data;
		end
	end

	// Step sequencer control and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (done && out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if ((st_q == ST_RUN) && done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Ray point, step count and result beat.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			deg_q   <= q_head.deg;
			left_q  <= q_head.left;
			rx_q    <= q_head.rx;
			ry_q    <= q_head.ry;
			yo_q    <= q_head.yo;
			steps_q <= '0;
		end else if (st_q == ST_RUN) begin
			if (done) begin
				if (out_free) begin
					out_data_q <= {4'b0, steps_q, sat_out(ry_q),
						sat_out({{(RY_W-RX_W){rx_q[RX_W-1]}}, rx_q})};
					out_user_q <= !deg_q && !at_max && wall;
				end
			end else begin
				rx_q    <= left_q ? (rx_q - TILE_Q8) : (rx_q + TILE_Q8);
				ry_q    <= ry_q + {{(RY_W-YO_W){yo_q[YO_W-1]}}, yo_q};
				steps_q <= steps_q + 4'd1;
			end
		end
	end

endmodule

FILE: rtl/core/grid_ray_vertical_wall_cast_core.sv
// Top level of the vertical-wall ray caster: front, queue and back.
// Depends on grvw_pkg, grvw_front, grvw_queue and grvw_back.
//
// Usage: each input beat on the s_ channel is one ray (player_x, player_y,
// ray_angle); each ray yields exactly one result beat on the m_ channel with
// the hit point, the number of grid lines crossed and, in m_tuser, whether a
// wall tile stopped the ray. The 8x8 wall bitmap must be loaded through
// cfg_wr_en and cfg_wr_data while the block is idle; the block itself does
// not enforce this. Reset clears the bitmap to an empty map. The step
// sequencer in the back tests one grid line per cycle and takes the next ray
// only after the result beat of the current ray has been registered. The
// front prepares the next ray meanwhile and a two-entry queue holds up to two
// prepared rays.
// When the receiver stalls, the result beat stays in the output register; the
// back finishes the current ray and waits, and the front keeps accepting until
// the queue and its own stage are full. Reset empties all stages.
module grid_ray_vertical_wall_cast_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [63:0]                     cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// player_x [17:0], player_y [35:18], ray_angle [45:36], zero pad [47:46]
	input  logic [grvw_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit_x [19:0], hit_y [39:20], steps_taken [43:40], zero pad [47:44]
	output logic [grvw_pkg::OUT_TDATA_W-1:0] m_tdata,
	// wall_found [0]
	output logic                            m_tuser
);
	import grvw_pkg::*;

	logic     push;
	ray_job_t push_job;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	ray_job_t q_head;

	grvw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	grvw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	grvw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

FILE: test/tb_grid_ray_vertical_wall_cast_core.sv
// Self-checking testbench for grid_ray_vertical_wall_cast_core: rays go in as stream beats,
// results are checked field by field against a cycle-free predictor of the caster.
// Depends on grvw_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_grid_ray_vertical_wall_cast_core;

	localparam int ANGLE_STEPS = 1024;
	localparam longint TILE = 16384;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int SEGMENTS = 12;
	localparam int RAYS_PER_SEGMENT = 125;

	// One ray beat, packed as on s_tdata (player_x in the low bits).
	typedef struct packed {
		logic [9:0]  angle;
		logic [17:0] py;
		logic [17:0] px;
	} ray_t;

	// One result: wall flag from m_tuser above the m_tdata fields.
	typedef struct packed {
		logic               found;
		logic [3:0]         steps;
		logic signed [19:0] hit_y;
		logic signed [19:0] hit_x;
	} hit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [63:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	// Predictor state: current wall bitmap and the Q8.8 tangent per angle code.
	logic [63:0] walls = '0;
	int          slope_q88 [ANGLE_STEPS];

	ray_t pending_rays[$];
	hit_t expected_hits[$];
	int   mismatches = 0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   beats_out = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   quiet_cycles = 0;

	grid_ray_vertical_wall_cast_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	always #5 clk = ~clk;

	// Tangent table built with the same 30-bit fraction series and rounding as the caster.
	initial begin : build_slopes
		longint unsigned u, v, phi, x2, st, ct, mag;
		longint          s, c;
		bit              neg;
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			u = (2 * k) % ANGLE_STEPS;
			if (2 * u == ANGLE_STEPS) begin
				slope_q88[k] = 32767;
			end else begin
				neg = (2 * u > ANGLE_STEPS);
				v   = neg ? ANGLE_STEPS - u : u;
				phi = grvw_pkg::PI_Q30 * v / ANGLE_STEPS;
				x2  = (phi * phi) >> 30;
				s   = longint'(phi);
				st  = phi;
				c   = longint'(grvw_pkg::ONE_Q30);
				ct  = grvw_pkg::ONE_Q30;
				for (int i = 1; i <= 12; i++) begin
					st = ((st * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
					ct = ((ct * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
					if (i % 2 == 1) begin
						s = s - longint'(st);
						c = c - longint'(ct);
					end else begin
						s = s + longint'(st);
						c = c + longint'(ct);
					end
				end
				if (s < 0) begin
					s = 0;
				end
				if (c <= 0) begin
					mag = 32768;
				end else begin
					mag = (longint'(s) * 256 + longint'(c) / 2) / longint'(c);
				end
				if (neg) begin
					slope_q88[k] = (mag > 32768) ? -32768 : -int'(mag);
				end else begin
					slope_q88[k] = (mag > 32767) ? 32767 : int'(mag);
				end
			end
		end
	end

	// Clamp a coordinate to the signed Q11.8 output range.
	function automatic logic signed [19:0] clamp_q11_8(longint v);
		if (v > 524287) begin
			return 20'sd524287;
		end
		if (v < -524288) begin
			return -20'sd524288;
		end
		return v[19:0];
	endfunction

	// Walk the ray across vertical grid lines until a wall or the step limit.
	function automatic hit_t cast_ray(ray_t r);
		longint px, py, rx, ry, xo, yo, t, col, row;
		int     steps;
		bit     found;
		hit_t   h;
		px = r.px;
		py = r.py;
		rx = px;
		ry = py;
		steps = 0;
		found = 1'b0;
		// Straight up or down is never cast; the origin comes back.
		if (r.angle != grvw_pkg::ANG_QTR && r.angle != grvw_pkg::ANG_3QTR) begin
			t  = slope_q88[r.angle];
			rx = (px >> 14) << 14;
			if (r.angle < grvw_pkg::ANG_QTR || r.angle > grvw_pkg::ANG_3QTR) begin
				rx = rx + TILE;
				xo = TILE;
				yo = 64 * t;
			end else begin
				// Looking left, test one LSB left of the line.
				rx = rx - 1;
				xo = -TILE;
				yo = -64 * t;
			end
			ry = py + (((rx - px) * t) >>> 8);
			while (steps < int'(grvw_pkg::MAX_STEPS) && !found) begin
				col = rx >>> 14;
				row = ry >>> 14;
				if (col >= 0 && col < 8 && row >= 0 && row < 8 && walls[row * 8 + col]) begin
					found = 1'b1;
				end else begin
					rx = rx + xo;
					ry = ry + yo;
					steps++;
				end
			end
		end
		h.hit_x = clamp_q11_8(rx);
		h.hit_y = clamp_q11_8(ry);
		h.steps = steps[3:0];
		h.found = found;
		return h;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
		mismatches++;
	endtask

	task automatic queue_ray(int px, int py, int angle);
		ray_t r;
		r.px = 18'(px);
		r.py = 18'(py);
		r.angle = 10'(angle);
		pending_rays.push_back(r);
	endtask

	// Wait until every ray has been accepted and answered, then let the pipe settle.
	task automatic drain_block();
		while (pending_rays.size() != 0 || expected_hits.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic load_walls(logic [63:0] map);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= map;
		walls = map;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Ray driver: offers the next queued ray, predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_hits.push_back(cast_ray(ray_t'(s_tdata[45:0])));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_rays.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, pending_rays.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		hit_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[43:0]};
				beats_out <= beats_out + 1;
				if (expected_hits.size() == 0) begin
					report_mismatch("results outstanding", 0, 1);
				end else begin
					want = expected_hits.pop_front();
					if (got.hit_x !== want.hit_x) begin
						report_mismatch("hit_x", want.hit_x, got.hit_x);
					end
					if (got.hit_y !== want.hit_y) begin
						report_mismatch("hit_y", want.hit_y, got.hit_y);
					end
					if (got.steps !== want.steps) begin
						report_mismatch("steps_taken", want.steps, got.steps);
					end
					if (got.found !== want.found) begin
						report_mismatch("wall_found", want.found, got.found);
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (beats_out >= HOLD_AT && !hold_done) begin
				m_tready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog: too long without any beat on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus sequence: directed rays under two maps, then random segments.
	initial begin
		int          dir_px [16];
		int          dir_py [16];
		int          dir_ang [16];
		logic [63:0] map;
		int          px, py, angle;
		dir_px  = '{1000, 262143, 0, 262143, 16484, 0, 20000, 60000,
			60000, 60000, 65536, 65536, 65536, 65536, 131071, 70000};
		dir_py  = '{1000, 262143, 0, 0, 100, 8000, 20000, 70000,
			70000, 70000, 65536, 65536, 65536, 65536, 131071, 0};
		dir_ang = '{256, 768, 0, 512, 512, 512, 128, 384,
			640, 896, 255, 257, 767, 769, 1023, 1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty map shows the step limit and clamping, border map shows
		// hits including the corner cell at index zero.
		src_idle_pct = 11;
		snk_idle_pct = 78;
		load_walls(64'h0);
		for (int i = 0; i < 16; i++) begin
			queue_ray(dir_px[i], dir_py[i], dir_ang[i]);
		end
		drain_block();
		load_walls(64'hFF81_8181_8181_81FF);
		for (int i = 0; i < 16; i++) begin
			queue_ray(dir_px[i], dir_py[i], dir_ang[i]);
		end
		drain_block();

		// Random segments; each ends with the sender paused until all results are in.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 4)
				0: begin
					src_idle_pct = 11;
					snk_idle_pct = 78;
				end
				1: begin
					src_idle_pct = 78;
					snk_idle_pct = 11;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			case (seg % 6)
				0: map = {$urandom, $urandom};
				1: map = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				2: map = 64'h0;
				3: map = {$urandom, $urandom} | {$urandom, $urandom};
				4: map = '1;
				default: map = 64'hFF81_8181_8181_81FF | ({$urandom, $urandom} & {$urandom, $urandom});
			endcase
			load_walls(map);
			for (int n = 0; n < RAYS_PER_SEGMENT; n++) begin
				// Mostly inside the map, sometimes anywhere in the full range.
				px = ($urandom_range(3) != 0) ? $urandom_range(131071) : $urandom_range(262143);
				py = ($urandom_range(3) != 0) ? $urandom_range(131071) : $urandom_range(262143);
				if ($urandom_range(9) == 0) begin
					angle = ($urandom_range(3) * 256 + $urandom_range(4) + 1022) % ANGLE_STEPS;
				end else begin
					angle = $urandom_range(ANGLE_STEPS - 1);
				end
				queue_ray(px, py, angle);
			end
			drain_block();
		end

		if (expected_hits.size() != 0) begin
			report_mismatch("results still outstanding", 0, expected_hits.size());
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/grvw_pkg.sv
rtl/core/grvw_front.sv
rtl/core/grvw_queue.sv
rtl/core/grvw_back.sv
rtl/core/grid_ray_vertical_wall_cast_core.sv
test/tb_grid_ray_vertical_wall_cast_core.sv
